/* design/sks_pkg.sv */
// Shared types and constants for the sorted key set unit.
package sks_pkg;

	// Store geometry
	localparam int CAPACITY = 64;
	localparam int KEY_BITS = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	typedef logic signed [KEY_BITS-1:0] key_t;
	typedef logic [CNT_W-1:0]           cnt_t;

	// Operation codes
	typedef enum logic [1:0] {
		OP_CONTAINS = 2'd0,
		OP_ADD      = 2'd1,
		OP_REMOVE   = 2'd2,
		OP_CLEAR    = 2'd3
	} op_t;

	// Error codes
	localparam logic ERR_OK   = 1'b0;
	localparam logic ERR_FULL = 1'b1;

	// Broadcast command to every cell of the row
	typedef struct packed {
		logic ins;  // insert key at the boundary, shift upper part right
		logic del;  // drop the boundary cell, shift upper part left
		key_t key;  // key under test
	} cell_ctl_t;

endpackage

/* design/sks_req_if.sv */
// Request channel: opcode and key beats into the unit.
interface sks_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic signed [31:0] key;

	modport source (output valid, output opcode, output key, input ready);
	modport sink   (input valid, input opcode, input key, output ready);
endinterface

/* design/sks_rsp_if.sv */
// Response channel: result beats out of the unit.
interface sks_rsp_if;
	logic       valid;
	logic       ready;
	logic       was_present;
	logic       changed;
	logic [6:0] position;
	logic [6:0] entry_count;
	logic       error;

	modport source (output valid, output was_present, output changed, output position,
		output entry_count, output error, input ready);
	modport sink   (input valid, input was_present, input changed, input position,
		input entry_count, input error, output ready);
endinterface

/* design/sks_cell.sv */
// One cell of the sorted row: holds a key, compares it, shifts with neighbors.
module sks_cell (
	input  logic                clk,
	input  sks_pkg::cell_ctl_t  ctl,
	input  logic                occupied,
	input  logic                left_lt,
	input  sks_pkg::key_t       left_key,
	input  sks_pkg::key_t       right_key,
	output sks_pkg::key_t       key_q,
	output logic                lt,
	output logic                eq
);

	// Compare against the broadcast key
	assign lt = occupied && (key_q < ctl.key);
	assign eq = occupied && (key_q == ctl.key);

	// Cells below the boundary hold; the rest load or shift
	always_ff @(posedge clk) begin
		if (ctl.ins && !lt) begin
			if (left_lt) begin
				key_q <= ctl.key;
			end else begin
				key_q <= left_key;
			end
		end else if (ctl.del && !lt) begin
			key_q <= right_key;
		end
	end

endmodule

/* design/sks_pos_enc.sv */
// Turns the row's compare vectors into an ordered position and a hit flag.
module sks_pos_enc (
	input  logic [sks_pkg::CAPACITY-1:0] lt,
	input  logic [sks_pkg::CAPACITY-1:0] eq,
	output sks_pkg::cnt_t                position,
	output logic                         present
);

	logic [sks_pkg::CAPACITY-1:0] prev_lt;
	logic [sks_pkg::CAPACITY-1:0] boundary;

	// Boundary is the first cell not below the key; lt is a prefix
	assign prev_lt  = {lt[sks_pkg::CAPACITY-2:0], 1'b1};
	assign boundary = prev_lt & ~lt;
	assign present  = |eq;

	// One-hot to index; every cell below means insertion at the end
	always_comb begin
		position = '0;
		for (int i = 0; i < sks_pkg::CAPACITY; i++) begin
			if (boundary[i]) begin
				position = position | sks_pkg::cnt_t'(unsigned'(i));
			end
		end
		if (lt[sks_pkg::CAPACITY-1]) begin
			position = sks_pkg::cnt_t'(sks_pkg::CAPACITY);
		end
	end

endmodule

/* design/sorted_key_set_unit.sv */
// Top level: sorted key set held in a row of compare-and-shift cells.
//
//   channel | dir | beat contents
//   --------+-----+--------------------------------------------------
//   req     | in  | opcode, key
//   rsp     | out | was_present, changed, position, entry_count, error
//
// One beat per cycle while responses are taken: every cell compares its key
// with the request in the same cycle, and the row shifts on the next edge.
// The response is registered as the request beat is accepted. A stalled
// response holds that register and stops request intake until it is taken.
// Reset empties the set at once; key registers keep whatever they held.
module sorted_key_set_unit (
	input  logic         clk,
	input  logic         arst_n,
	sks_req_if.sink      req,
	sks_rsp_if.source    rsp
);

	localparam int CAP = sks_pkg::CAPACITY;

	sks_pkg::cnt_t       count_q;
	sks_pkg::cell_ctl_t  ctl;
	sks_pkg::key_t       cell_key [CAP];
	logic [CAP-1:0]      occ;
	logic [CAP-1:0]      lt;
	logic [CAP-1:0]      eq;
	sks_pkg::cnt_t       pos;
	logic                present;
	logic                accept;
	logic                full;
	logic                is_add;
	logic                is_rem;
	logic                is_clr;
	logic                do_ins;
	logic                do_del;
	logic                add_err;
	logic                out_valid_q;

	// Handshake
	assign req.ready = !out_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;

	// Decode
	assign is_add  = (sks_pkg::op_t'(req.opcode) == sks_pkg::OP_ADD);
	assign is_rem  = (sks_pkg::op_t'(req.opcode) == sks_pkg::OP_REMOVE);
	assign is_clr  = (sks_pkg::op_t'(req.opcode) == sks_pkg::OP_CLEAR);
	assign full    = (count_q == sks_pkg::cnt_t'(CAP));
	assign do_ins  = is_add && !present && !full;
	assign do_del  = is_rem && present;
	assign add_err = is_add && !present && full;

	assign ctl.ins = accept && do_ins;
	assign ctl.del = accept && do_del;
	assign ctl.key = sks_pkg::key_t'(req.key);

	// Row of cells
	for (genvar g = 0; g < CAP; g++) begin : g_cell
		sks_pkg::key_t left_key;
		sks_pkg::key_t right_key;
		logic          left_lt;

		assign occ[g] = (sks_pkg::cnt_t'(g) < count_q);

		if (g == 0) begin : g_first
			assign left_key = cell_key[g];
			assign left_lt  = 1'b1;
		end else begin : g_mid
			assign left_key = cell_key[g-1];
			assign left_lt  = lt[g-1];
		end

		if (g == CAP - 1) begin : g_last
			assign right_key = cell_key[g];
		end else begin : g_inner
			assign right_key = cell_key[g+1];
		end

		sks_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occupied  (occ[g]),
			.left_lt   (left_lt),
			.left_key  (left_key),
			.right_key (right_key),
			.key_q     (cell_key[g]),
			.lt        (lt[g]),
			.eq        (eq[g])
		);
	end

	// Position and hit
	sks_pos_enc u_enc (
		.lt       (lt),
		.eq       (eq),
		.position (pos),
		.present  (present)
	);

	// Key count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			if (is_clr) begin
				count_q <= '0;
			end else if (do_ins) begin
				count_q <= count_q + sks_pkg::cnt_t'(1);
			end else if (do_del) begin
				count_q <= count_q - sks_pkg::cnt_t'(1);
			end
		end
	end

	// Response valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Response payload
	always_ff @(posedge clk) begin
		if (accept) begin
			if (is_clr) begin
				rsp.was_present <= 1'b0;
				rsp.changed     <= 1'b0;
				rsp.position    <= '0;
				rsp.entry_count <= '0;
				rsp.error       <= sks_pkg::ERR_OK;
			end else begin
				rsp.was_present <= present;
				rsp.changed     <= do_ins || do_del;
				rsp.position    <= 7'(pos);
				if (do_ins) begin
					rsp.entry_count <= 7'(count_q + sks_pkg::cnt_t'(1));
				end else if (do_del) begin
					rsp.entry_count <= 7'(count_q - sks_pkg::cnt_t'(1));
				end else begin
					rsp.entry_count <= 7'(count_q);
				end
				rsp.error <= add_err ? sks_pkg::ERR_FULL : sks_pkg::ERR_OK;
			end
		end
	end

	assign rsp.valid = out_valid_q;

endmodule
